FILE: src/ptwt_pkg.sv
package ptwt_pkg;

   localparam int STORE_FRAMES      = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int LEVELS            = 4;

   localparam int PAGE_SHIFT  = 12;
   localparam int INDEX_BITS  = 9;
   localparam int INDEX_MASK  = (1 << 9) - 1;
   localparam int STORE_DEPTH = STORE_FRAMES * ENTRIES_PER_TABLE;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int LEVEL_W     = $clog2(LEVELS);

   localparam int FRAME_W      = 40;
   localparam int VA_W         = 48;
   localparam int VA_REG_W     = 49;
   localparam int WORD_W       = 64;
   localparam int WORD_INDEX_W = 15;
   localparam int PHYS_W       = 52;
   localparam int STATUS_W     = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 64;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int PRESENT_BIT = 0;
   localparam int USER_BIT    = 2;
   localparam int FRAME_LSB   = 12;

   localparam logic [VA_REG_W-1:0] VA_UPPER_RESET = VA_REG_W'(64'h0000_8000_0000_0000);

   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_FRAME = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VA_LOWER   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VA_UPPER   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE       = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_MID_ABSENT  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_LEAF_ABSENT = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_USER        = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FRAME       = 3'd5;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_WALK   = 2'd1;
   localparam logic [1:0] KIND_RESULT = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [STATUS_W-1:0] status;
      logic                wr_en;
      logic [STORE_AW-1:0] addr;
      logic [WORD_W-1:0]   data;
      logic [VA_W-1:0]     va;
      logic                user;
   } ptwt_op_type;

   function automatic logic [INDEX_BITS-1:0] level_index(input logic [VA_W-1:0] va,
                                                         input logic [LEVEL_W-1:0] level);
      logic [63:0] wide;
      wide = (64'(va) >> (PAGE_SHIFT + INDEX_BITS * int'(level))) & 64'(INDEX_MASK);
      return wide[INDEX_BITS-1:0];
   endfunction

   function automatic logic [STORE_AW-1:0] table_addr(input logic [FRAME_W-1:0] frame,
                                                      input logic [INDEX_BITS-1:0] idx);
      logic [FRAME_W+INDEX_BITS-1:0] full;
      full = {frame, idx};
      return full[STORE_AW-1:0];
   endfunction

   function automatic logic [STORE_AW-1:0] word_addr(input logic [WORD_INDEX_W-1:0] idx);
      logic [31:0] full;
      full = 32'(idx);
      return full[STORE_AW-1:0];
   endfunction

   function automatic logic word_in_store(input logic [WORD_INDEX_W-1:0] idx);
      return 32'(idx) < 32'(STORE_DEPTH);
   endfunction

   function automatic logic frame_in_store(input logic [FRAME_W-1:0] frame);
      return frame < FRAME_W'(STORE_FRAMES);
   endfunction

endpackage

FILE: src/ptwt_ram.sv
module ptwt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ptwt_front.sv
module ptwt_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_cmd,
   input  logic [ptwt_pkg::WORD_INDEX_W-1:0]      req_word_index,
   input  logic [ptwt_pkg::WORD_W-1:0]            req_word_value,
   input  logic [ptwt_pkg::VA_W-1:0]              req_virt_addr,
   input  logic                                   req_user_mode,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ptwt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ptwt_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   clear_busy,
   input  logic                                   q_full,
   output logic                                   q_push,
   output ptwt_pkg::ptwt_op_type                  q_op
);

   logic [ptwt_pkg::FRAME_W-1:0]  root_frame_ff, root_frame_in;
   logic [ptwt_pkg::VA_REG_W-1:0] va_lower_ff, va_lower_in;
   logic [ptwt_pkg::VA_REG_W-1:0] va_upper_ff, va_upper_in;
   logic                          valid_ff, valid_in;
   ptwt_pkg::ptwt_op_type         op_ff, op_in, classified;
   logic                          accept;
   logic                          out_of_range;

   assign csr_ready = 1'b1;
   assign req_full  = clear_busy | (valid_ff & q_full);
   assign accept    = req_push & ~req_full;
   assign q_push    = valid_ff;
   assign q_op      = op_ff;

   always_comb begin
      root_frame_in = root_frame_ff;
      va_lower_in   = va_lower_ff;
      va_upper_in   = va_upper_ff;
      if (csr_valid) begin
         case (csr_index)
            ptwt_pkg::CSR_ROOT_FRAME: root_frame_in = csr_wdata[ptwt_pkg::FRAME_W-1:0];
            ptwt_pkg::CSR_VA_LOWER:   va_lower_in   = csr_wdata[ptwt_pkg::VA_REG_W-1:0];
            ptwt_pkg::CSR_VA_UPPER:   va_upper_in   = csr_wdata[ptwt_pkg::VA_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      out_of_range = ({1'b0, req_virt_addr} >= va_upper_ff) ||
                     ({1'b0, req_virt_addr} < va_lower_ff);
      classified        = '0;
      classified.data   = req_word_value;
      classified.va     = req_virt_addr;
      classified.user   = req_user_mode;
      classified.status = ptwt_pkg::STATUS_OK;
      if (req_cmd == ptwt_pkg::CMD_WRITE) begin
         classified.kind  = ptwt_pkg::KIND_WRITE;
         classified.wr_en = ptwt_pkg::word_in_store(req_word_index);
         classified.addr  = ptwt_pkg::word_addr(req_word_index);
      end else if (out_of_range) begin
         classified.kind   = ptwt_pkg::KIND_RESULT;
         classified.status = ptwt_pkg::STATUS_RANGE;
      end else if (!ptwt_pkg::frame_in_store(root_frame_ff)) begin
         classified.kind   = ptwt_pkg::KIND_RESULT;
         classified.status = ptwt_pkg::STATUS_FRAME;
      end else begin
         classified.kind = ptwt_pkg::KIND_WALK;
         classified.addr = ptwt_pkg::table_addr(root_frame_ff,
                              ptwt_pkg::level_index(req_virt_addr,
                                 ptwt_pkg::LEVEL_W'(ptwt_pkg::LEVELS - 1)));
      end
   end

   always_comb begin
      valid_in = accept | (valid_ff & q_full);
      op_in    = accept ? classified : op_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= '0;
         va_lower_ff   <= '0;
         va_upper_ff   <= ptwt_pkg::VA_UPPER_RESET;
         valid_ff      <= 1'b0;
      end else begin
         root_frame_ff <= root_frame_in;
         va_lower_ff   <= va_lower_in;
         va_upper_ff   <= va_upper_in;
         valid_ff      <= valid_in;
      end
      op_ff <= op_in;
   end

endmodule

FILE: src/ptwt_queue.sv
module ptwt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ptwt_pkg::ptwt_op_type push_op,
   output logic                  full,
   input  logic                  pop,
   output ptwt_pkg::ptwt_op_type pop_op,
   output logic                  empty
);

   localparam int PTR_W = (ptwt_pkg::QUEUE_AW > 0) ? ptwt_pkg::QUEUE_AW : 1;

   ptwt_pkg::ptwt_op_type            entries_ff [ptwt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]                 wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [ptwt_pkg::QUEUE_AW:0]      count_ff, count_in;
   logic                             do_push, do_pop;

   assign full    = count_ff == (ptwt_pkg::QUEUE_AW+1)'(ptwt_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_op  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ptwt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ptwt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: src/ptwt_back.sv
module ptwt_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  ptwt_pkg::ptwt_op_type             q_op,
   output logic                              q_pop,
   output logic                              clear_busy,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [ptwt_pkg::PHYS_W-1:0]       rsp_phys_base,
   output logic [ptwt_pkg::STATUS_W-1:0]     rsp_status
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [ptwt_pkg::STORE_AW-1:0]    clear_cnt_ff, clear_cnt_in;
   logic [ptwt_pkg::LEVEL_W-1:0]     level_ff, level_in;
   logic [ptwt_pkg::VA_W-1:0]        va_ff, va_in;
   logic                             user_ff, user_in;
   logic                             out_valid_ff, out_valid_in;
   logic [ptwt_pkg::PHYS_W-1:0]      base_ff, base_in;
   logic [ptwt_pkg::STATUS_W-1:0]    status_ff, status_in;

   logic                             ram_we;
   logic [ptwt_pkg::STORE_AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [ptwt_pkg::WORD_W-1:0]      ram_wr_data, ram_rd_data;
   logic [ptwt_pkg::FRAME_W-1:0]     entry_frame;
   logic [ptwt_pkg::INDEX_BITS-1:0]  next_idx;
   logic                             slot_free;

   ptwt_ram #(
      .WIDTH (ptwt_pkg::WORD_W),
      .DEPTH (ptwt_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign clear_busy    = state_ff == S_CLEAR;
   assign slot_free     = ~out_valid_ff | rsp_pop;
   assign rsp_empty     = ~out_valid_ff;
   assign rsp_phys_base = base_ff;
   assign rsp_status    = status_ff;
   assign entry_frame   = ram_rd_data[ptwt_pkg::FRAME_LSB +: ptwt_pkg::FRAME_W];
   assign next_idx      = ptwt_pkg::level_index(va_ff, level_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      level_in     = level_ff;
      va_in        = va_ff;
      user_in      = user_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      base_in      = base_ff;
      status_in    = status_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_wr_addr  = q_op.addr;
      ram_wr_data  = q_op.data;
      ram_rd_addr  = q_op.addr;
      case (state_ff)
         S_CLEAR: begin
            ram_we       = 1'b1;
            ram_wr_addr  = clear_cnt_ff;
            ram_wr_data  = '0;
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == ptwt_pkg::STORE_AW'(ptwt_pkg::STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty && slot_free) begin
               q_pop = 1'b1;
               case (q_op.kind)
                  ptwt_pkg::KIND_WRITE: begin
                     ram_we       = q_op.wr_en;
                     out_valid_in = 1'b1;
                     base_in      = '0;
                     status_in    = ptwt_pkg::STATUS_OK;
                  end
                  ptwt_pkg::KIND_WALK: begin
                     va_in    = q_op.va;
                     user_in  = q_op.user;
                     level_in = ptwt_pkg::LEVEL_W'(ptwt_pkg::LEVELS - 1);
                     state_in = S_WALK;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                     base_in      = '0;
                     status_in    = q_op.status;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (level_ff != '0) begin
               if (!ram_rd_data[ptwt_pkg::PRESENT_BIT]) begin
                  out_valid_in = 1'b1;
                  base_in      = '0;
                  status_in    = ptwt_pkg::STATUS_MID_ABSENT;
                  state_in     = S_IDLE;
               end else if (!ptwt_pkg::frame_in_store(entry_frame)) begin
                  out_valid_in = 1'b1;
                  base_in      = '0;
                  status_in    = ptwt_pkg::STATUS_FRAME;
                  state_in     = S_IDLE;
               end else begin
                  ram_rd_addr = ptwt_pkg::table_addr(entry_frame, next_idx);
                  level_in    = level_ff - 1'b1;
               end
            end else begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (!ram_rd_data[ptwt_pkg::PRESENT_BIT]) begin
                  base_in   = '0;
                  status_in = ptwt_pkg::STATUS_LEAF_ABSENT;
               end else if (ram_rd_data[ptwt_pkg::USER_BIT] != user_ff) begin
                  base_in   = '0;
                  status_in = ptwt_pkg::STATUS_USER;
               end else begin
                  base_in   = {entry_frame, {ptwt_pkg::PAGE_SHIFT{1'b0}}};
                  status_in = ptwt_pkg::STATUS_OK;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         out_valid_ff <= out_valid_in;
      end
      level_ff  <= level_in;
      va_ff     <= va_in;
      user_ff   <= user_in;
      base_ff   <= base_in;
      status_ff <= status_in;
   end

   // result slot is kept free for the whole walk
   a_walk_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !out_valid_ff)
      else $error("result pending during walk");

   // nothing reaches the queue while the store is being cleared
   a_clear_queue_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (q_empty && !q_pop))
      else $error("queue active during clear");

   // each walk cycle descends exactly one level
   a_walk_descends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && $past(state_ff) == S_WALK)
         |-> (level_ff == $past(level_ff) - 1'b1))
      else $error("walk level skipped");

endmodule

FILE: src/page_table_walk_translate.sv
// channel  direction  handshake               payload
// req      in         push / full             cmd, word_index, word_value, virt_addr, user_mode
// rsp      out        pop / empty             phys_base, status
// csr      in         valid / ready (ready=1) index, wdata
//
// A translation that walks does one table store read per level, each dependent on the last.
// After reset the table store (STORE_FRAMES*512 = 32768 words) is zeroed, one word a cycle,
// with full held high; csr writes are taken throughout.
// A two-entry queue separates classification from the walk; a result waits in an output
// register while further transactions are accepted until the queue and the front register fill.
module page_table_walk_translate (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_cmd,
   input  logic [ptwt_pkg::WORD_INDEX_W-1:0]  req_word_index,
   input  logic [ptwt_pkg::WORD_W-1:0]        req_word_value,
   input  logic [ptwt_pkg::VA_W-1:0]          req_virt_addr,
   input  logic                               req_user_mode,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [ptwt_pkg::PHYS_W-1:0]        rsp_phys_base,
   output logic [ptwt_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptwt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ptwt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                  clear_busy;
   logic                  q_full, q_push, q_empty, q_pop;
   ptwt_pkg::ptwt_op_type q_push_op, q_pop_op;

   ptwt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_word_index (req_word_index),
      .req_word_value (req_word_value),
      .req_virt_addr  (req_virt_addr),
      .req_user_mode  (req_user_mode),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .clear_busy     (clear_busy),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_op           (q_push_op)
   );

   ptwt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .full    (q_full),
      .pop     (q_pop),
      .pop_op  (q_pop_op),
      .empty   (q_empty)
   );

   ptwt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_op          (q_pop_op),
      .q_pop         (q_pop),
      .clear_busy    (clear_busy),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_phys_base (rsp_phys_base),
      .rsp_status    (rsp_status)
   );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ptwt_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES      = 8;
   localparam int LONG_HOLD   = 400;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [VA_W-1:0] CHAIN_VA = 48'h0080_8060_4ABC;

   typedef struct packed {
      logic [PHYS_W-1:0]   base;
      logic [STATUS_W-1:0] status;
   } walk_result_t;

   typedef struct packed {
      logic                    cmd;
      logic [WORD_INDEX_W-1:0] idx;
      logic [WORD_W-1:0]       value;
      logic [VA_W-1:0]         va;
      logic                    user;
      logic                    typed;
      walk_result_t            result;
   } stim_row_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic                    req_cmd = 1'b0;
   logic [WORD_INDEX_W-1:0] req_word_index = '0;
   logic [WORD_W-1:0]       req_word_value = '0;
   logic [VA_W-1:0]         req_virt_addr = '0;
   logic                    req_user_mode = 1'b0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic [PHYS_W-1:0]       rsp_phys_base;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   page_table_walk_translate dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_word_index (req_word_index),
      .req_word_value (req_word_value),
      .req_virt_addr  (req_virt_addr),
      .req_user_mode  (req_user_mode),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_phys_base  (rsp_phys_base),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   logic [WORD_W-1:0]   shadow_store [STORE_DEPTH];
   logic [FRAME_W-1:0]  root_q = '0;
   logic [VA_REG_W-1:0] va_lower_q = '0;
   logic [VA_REG_W-1:0] va_upper_q = VA_UPPER_RESET;

   walk_result_t    pending_results [$];
   stim_row_t       directed_rows [23];
   logic [VA_W-1:0] recent_va [16];
   int              recent_ptr = 0;

   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   bit long_hold_pending = 1'b0;

   logic [63:0] cfg_root [PHASES];
   logic [63:0] cfg_lower [PHASES];
   logic [63:0] cfg_upper [PHASES];
   int          phase_items [PHASES];
   int          phase_send [PHASES];
   int          phase_stall [PHASES];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [STATUS_W-1:0] walk_table(input logic [VA_W-1:0] va,
                                                     input logic user,
                                                     output logic [PHYS_W-1:0] base);
      logic [FRAME_W-1:0]    frame;
      logic [WORD_W-1:0]     entry;
      logic [INDEX_BITS-1:0] idx;
      base = '0;
      if ({1'b0, va} >= va_upper_q || {1'b0, va} < va_lower_q) return STATUS_RANGE;
      frame = root_q;
      if (frame >= STORE_FRAMES) return STATUS_FRAME;
      for (int lvl = LEVELS - 1; lvl > 0; lvl--) begin
         idx = va[PAGE_SHIFT + INDEX_BITS * lvl +: INDEX_BITS];
         entry = shadow_store[frame * ENTRIES_PER_TABLE + idx];
         if (!entry[PRESENT_BIT]) return STATUS_MID_ABSENT;
         frame = entry[FRAME_LSB +: FRAME_W];
         if (frame >= STORE_FRAMES) return STATUS_FRAME;
      end
      idx = va[PAGE_SHIFT +: INDEX_BITS];
      entry = shadow_store[frame * ENTRIES_PER_TABLE + idx];
      if (!entry[PRESENT_BIT]) return STATUS_LEAF_ABSENT;
      if (entry[USER_BIT] != user) return STATUS_USER;
      base = {entry[FRAME_LSB +: FRAME_W], 12'h000};
      return STATUS_OK;
   endfunction

   task automatic send_item(input logic cmd, input logic [WORD_INDEX_W-1:0] idx,
                            input logic [WORD_W-1:0] value, input logic [VA_W-1:0] va,
                            input logic user, input logic typed,
                            input walk_result_t typed_result);
      walk_result_t res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_cmd        <= cmd;
      req_word_index <= idx;
      req_word_value <= value;
      req_virt_addr  <= va;
      req_user_mode  <= user;
      do @(posedge clock); while (req_full);
      res = '0;
      if (cmd == CMD_WRITE) begin
         if (idx < STORE_DEPTH) shadow_store[idx] = value;
      end else begin
         res.status = walk_table(va, user, res.base);
      end
      pending_results.push_back(typed ? typed_result : res);
      items_sent++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_ROOT_FRAME: root_q = data[FRAME_W-1:0];
         CSR_VA_LOWER:   va_lower_q = data[VA_REG_W-1:0];
         CSR_VA_UPPER:   va_upper_q = data[VA_REG_W-1:0];
         default: ;
      endcase
   endtask

   // builds a random walk path from the current root, then translates through it
   task automatic map_and_walk();
      logic [VA_W-1:0]       va;
      logic [FRAME_W-1:0]    frame;
      logic [FRAME_W-1:0]    next_frame;
      logic [WORD_W-1:0]     entry;
      logic [INDEX_BITS-1:0] idx;
      logic [63:0]           span;
      span = 64'(va_upper_q) - 64'(va_lower_q);
      if (va_upper_q > va_lower_q) va = VA_W'(64'(va_lower_q) + rand64() % span);
      else va = VA_W'(rand64());
      frame = root_q;
      entry = '0;
      for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
         idx = va[PAGE_SHIFT + INDEX_BITS * lvl +: INDEX_BITS];
         entry = rand64();
         entry[PRESENT_BIT] = ($urandom_range(0, 15) != 0);
         next_frame = ($urandom_range(0, 15) == 0) ? FRAME_W'(rand64())
                                                  : FRAME_W'($urandom_range(0, STORE_FRAMES - 1));
         if (lvl > 0) entry[FRAME_LSB +: FRAME_W] = next_frame;
         if (frame < STORE_FRAMES)
            send_item(CMD_WRITE, WORD_INDEX_W'(frame * ENTRIES_PER_TABLE + idx), entry,
                      VA_W'(rand64()), 1'($urandom), 1'b0, '0);
         frame = next_frame;
      end
      recent_va[recent_ptr % 16] = va;
      recent_ptr++;
      send_item(CMD_TRANSLATE, WORD_INDEX_W'($urandom), rand64(), va,
                ($urandom_range(0, 7) == 0) ? !entry[USER_BIT] : entry[USER_BIT], 1'b0, '0);
   endtask

   task automatic run_items(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         case ($urandom_range(0, 15))
            10, 11: send_item(CMD_WRITE, WORD_INDEX_W'($urandom), rand64(), VA_W'(rand64()),
                              1'($urandom), 1'b0, '0);
            12, 13: send_item(CMD_TRANSLATE, WORD_INDEX_W'($urandom), rand64(),
                              VA_W'(rand64()), 1'($urandom), 1'b0, '0);
            14, 15: send_item(CMD_TRANSLATE, WORD_INDEX_W'($urandom), rand64(),
                              recent_va[$urandom_range(0, 15)], 1'($urandom), 1'b0, '0);
            default: map_and_walk();
         endcase
      end
   endtask

   task automatic check_result();
      walk_result_t want;
      if (pending_results.size() == 0) begin
         error_count++;
         $display("%0t: unexpected transaction phys_base=%h status=%0d",
                  $time, rsp_phys_base, rsp_status);
      end else begin
         want = pending_results.pop_front();
         results_checked++;
         if (rsp_phys_base !== want.base) begin
            error_count++;
            $display("%0t: phys_base expected %h got %h", $time, want.base, rsp_phys_base);
         end
         if (rsp_status !== want.status) begin
            error_count++;
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) check_result();
         if (long_hold_pending) begin
            hold_left = LONG_HOLD;
            long_hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      foreach (recent_va[i]) recent_va[i] = '0;

      cfg_root  = '{64'd0, 64'd63, 64'd17, 64'd9, 64'h0000_00FF_FFFF_FFFF, 64'd5,
                    64'hFFFF_FF00_0000_001E, 64'd2};
      cfg_lower = '{64'd0, 64'd0, 64'h0000_0000_0010_0000, 64'h1000, 64'd0,
                    64'h0001_0000_0000_0000, 64'hFFFE_0000_0000_0000, 64'd0};
      cfg_upper = '{64'h0000_8000_0000_0000, 64'h0001_0000_0000_0000,
                    64'h0000_0100_0000_0000, 64'h0001_0000_0000_0000,
                    64'h0001_0000_0000_0000, 64'h0001_0000_0000_0000,
                    64'hFFFF_0000_0000_0000, 64'h0000_8000_0000_0000};
      phase_items = '{250, 250, 250, 250, 60, 40, 200, 150};
      phase_send  = '{0, 64, 0, 30, 64, 30, 64, 0};
      phase_stall = '{0, 0, 64, 30, 64, 30, 0, 64};

      // cleared store, reset config
      directed_rows[0]  = {CMD_TRANSLATE, 15'd0, 64'd0, 48'd0, 1'b0,
                           1'b1, 52'd0, STATUS_MID_ABSENT};
      directed_rows[1]  = {CMD_TRANSLATE, 15'd0, 64'd0, 48'h7FFF_FFFF_FFFF, 1'b1,
                           1'b1, 52'd0, STATUS_MID_ABSENT};
      directed_rows[2]  = {CMD_TRANSLATE, 15'd0, 64'd0, 48'h8000_0000_0000, 1'b0,
                           1'b1, 52'd0, STATUS_RANGE};
      directed_rows[3]  = {CMD_TRANSLATE, 15'd0, 64'd0, 48'hFFFF_FFFF_FFFF, 1'b1,
                           1'b1, 52'd0, STATUS_RANGE};
      // chain 0 -> 1 -> 2 -> 3 -> leaf
      directed_rows[4]  = {CMD_WRITE, 15'd1, 64'h1001, 48'd0, 1'b0, 1'b1, 52'd0, STATUS_OK};
      directed_rows[5]  = {CMD_WRITE, 15'd514, 64'h2001, 48'd0, 1'b0, 1'b1, 52'd0, STATUS_OK};
      directed_rows[6]  = {CMD_WRITE, 15'd1027, 64'h3001, 48'd0, 1'b0, 1'b1, 52'd0, STATUS_OK};
      directed_rows[7]  = {CMD_TRANSLATE, 15'd0, 64'd0, CHAIN_VA, 1'b1, 1'b0, 52'd0, STATUS_OK};
      directed_rows[8]  = {CMD_WRITE, 15'd1540, 64'hFFFF_FFFF_FFFF_FFFF, 48'd0, 1'b0,
                           1'b1, 52'd0, STATUS_OK};
      directed_rows[9]  = {CMD_TRANSLATE, 15'd0, 64'd0, CHAIN_VA, 1'b1,
                           1'b1, 52'hF_FFFF_FFFF_F000, STATUS_OK};
      directed_rows[10] = {CMD_TRANSLATE, 15'd0, 64'd0, CHAIN_VA, 1'b0,
                           1'b1, 52'd0, STATUS_USER};
      directed_rows[11] = {CMD_WRITE, 15'd1540, 64'h0000_0000_0ABC_D001, 48'd0, 1'b0,
                           1'b1, 52'd0, STATUS_OK};
      directed_rows[12] = {CMD_TRANSLATE, 15'd0, 64'd0, CHAIN_VA, 1'b0, 1'b0, 52'd0, STATUS_OK};
      directed_rows[13] = {CMD_TRANSLATE, 15'd0, 64'd0, CHAIN_VA, 1'b1, 1'b0, 52'd0, STATUS_OK};
      // intermediate frame outside store, then absent, then restored
      directed_rows[14] = {CMD_WRITE, 15'd514, 64'h0000_0000_0004_0001, 48'd0, 1'b0,
                           1'b1, 52'd0, STATUS_OK};
      directed_rows[15] = {CMD_TRANSLATE, 15'd0, 64'd0, CHAIN_VA, 1'b0, 1'b0, 52'd0, STATUS_OK};
      directed_rows[16] = {CMD_WRITE, 15'd514, 64'h2000, 48'd0, 1'b0, 1'b1, 52'd0, STATUS_OK};
      directed_rows[17] = {CMD_TRANSLATE, 15'd0, 64'd0, CHAIN_VA, 1'b0, 1'b0, 52'd0, STATUS_OK};
      directed_rows[18] = {CMD_WRITE, 15'd514, 64'h2001, 48'd0, 1'b0, 1'b1, 52'd0, STATUS_OK};
      directed_rows[19] = {CMD_WRITE, 15'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                           1'b1, 1'b1, 52'd0, STATUS_OK};
      directed_rows[20] = {CMD_WRITE, 15'd0, 64'hFFFF_FFFF_FFFF_FFFF, 48'd0, 1'b0,
                           1'b1, 52'd0, STATUS_OK};
      directed_rows[21] = {CMD_TRANSLATE, 15'd0, 64'd0, 48'd0, 1'b0, 1'b0, 52'd0, STATUS_OK};
      directed_rows[22] = {CMD_TRANSLATE, 15'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF,
                           48'h0080_8060_4FFF, 1'b0, 1'b0, 52'd0, STATUS_OK};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].value,
                   directed_rows[i].va, directed_rows[i].user, directed_rows[i].typed,
                   directed_rows[i].result);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         repeat (8) @(posedge clock);
         write_csr(CSR_ROOT_FRAME, cfg_root[p]);
         write_csr(CSR_VA_LOWER, cfg_lower[p]);
         write_csr(CSR_VA_UPPER, cfg_upper[p]);
         if (p == 6) write_csr(CSR_UNUSED, '1);
         csr_valid <= 1'b0;
         @(posedge clock);
         send_idle_pct = phase_send[p];
         rsp_stall_pct = phase_stall[p];
         if (p == 2) long_hold_pending = 1'b1;
         run_items(phase_items[p] / 2);
         if (p == 3) drain_results();
         run_items(phase_items[p] - phase_items[p] / 2);
      end

      drain_results();
      repeat (20) @(posedge clock);
      $display("Covered %0d transactions (table writes, walks, range/absent/user/frame faults)",
               items_sent);
      $display("over %0d register settings with idle and stall mixes; %0d results checked",
               PHASES, results_checked);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
